### rtl/kbd_rpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kbd_rpt_pkg;

    localparam int SLOT_COUNT   = 6;
    localparam int BITMAP_BYTES = 32;

    localparam int SCAN_MAX = (SLOT_COUNT > BITMAP_BYTES) ? SLOT_COUNT : BITMAP_BYTES;
    localparam int SLOT_IW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int BMP_IW   = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
    localparam int IDX_W    = (SCAN_MAX > 1) ? $clog2(SCAN_MAX) : 1;

    localparam int FUNC_W  = 2;
    localparam int KEY_W   = 8;
    localparam int COUNT_W = 6;

    // Item operations
    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DEL   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLR   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_PROTOCOL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NKRO_ON         = 2'd1;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  code;
        logic              nkro;
    } kr_req_t;

    typedef struct packed {
        logic [KEY_W-1:0]   first_key;
        logic [COUNT_W-1:0] key_count;
        logic               added;
        logic               query_hit;
    } kr_res_t;

    // Position of the highest set bit, 0 when none is set
    function automatic logic [2:0] top_bit(input logic [7:0] v);
        logic [2:0] r;
        r = 3'd0;
        for (int b = 0; b < 8; b++) begin
            if (v[b]) begin
                r = 3'(b);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/kbd_rpt_core.sv
`timescale 1ns / 1ps
`default_nettype none

module kbd_rpt_core
    import kbd_rpt_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    start,
    input  wire kr_req_t req,
    output logic         idle,
    output logic         done,
    input  wire logic    take,
    output kr_res_t      res
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_PRESCAN = 2'd1;
    localparam logic [1:0] ST_SCAN    = 2'd2;
    localparam logic [1:0] ST_HOLD    = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    kr_req_t            req_reg;
    logic               dup_reg, dup_next;
    logic               empty_found_reg, empty_found_next;
    logic [SLOT_IW-1:0] empty_idx_reg, empty_idx_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [KEY_W-1:0]   first_reg, first_next;
    logic               first_found_reg, first_found_next;
    logic               hit_reg, hit_next;

    logic [KEY_W-1:0] slot_reg [SLOT_COUNT];
    logic [7:0]       bmp_reg  [BITMAP_BYTES];

    logic [7:0] cur;
    logic [7:0] new_val;
    logic [7:0] mask;
    logic       byte_sel;
    logic       eq_cur;
    logic       held;
    logic       last;
    logic       fill_slot;

    // Shared entry unit: read one entry, update it, compare it
    always_comb begin
        cur = req_reg.nkro ? bmp_reg[idx_reg[BMP_IW-1:0]] : slot_reg[idx_reg[SLOT_IW-1:0]];
        mask     = 8'b1 << req_reg.code[2:0];
        byte_sel = ({3'b000, req_reg.code[7:3]} == 8'(idx_reg));
        eq_cur   = (cur == req_reg.code);
        new_val  = cur;
        unique case (req_reg.func)
            FUNC_ADD: begin
                if (req_reg.nkro && byte_sel) begin
                    new_val = cur | mask;
                end
            end
            FUNC_DEL: begin
                if (req_reg.nkro) begin
                    if (byte_sel) begin
                        new_val = cur & ~mask;
                    end
                end else if (eq_cur) begin
                    new_val = 8'd0;
                end
            end
            FUNC_CLR:   new_val = 8'd0;
            FUNC_QUERY: new_val = cur;
            default:    new_val = cur;
        endcase
        if (req_reg.nkro) begin
            held = byte_sel && new_val[req_reg.code[2:0]] && (req_reg.code != 8'd0);
        end else begin
            held = (new_val == req_reg.code) && (req_reg.code != 8'd0);
        end
        last = req_reg.nkro ? (idx_reg == IDX_W'(BITMAP_BYTES - 1))
                            : (idx_reg == IDX_W'(SLOT_COUNT - 1));
    end

    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        dup_next         = dup_reg;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        count_next       = count_reg;
        first_next       = first_reg;
        first_found_next = first_found_reg;
        hit_next         = hit_reg;
        fill_slot        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    idx_next         = '0;
                    dup_next         = 1'b0;
                    empty_found_next = 1'b0;
                    count_next       = '0;
                    first_next       = '0;
                    first_found_next = 1'b0;
                    hit_next         = 1'b0;
                    state_next = (!req.nkro && req.func == FUNC_ADD) ? ST_PRESCAN : ST_SCAN;
                end
            end
            ST_PRESCAN: begin
                // look for a duplicate and the first empty slot before filling
                if (eq_cur) begin
                    dup_next = 1'b1;
                end
                if (!empty_found_reg && cur == 8'd0) begin
                    empty_found_next = 1'b1;
                    empty_idx_next   = idx_reg[SLOT_IW-1:0];
                end
                if (last) begin
                    fill_slot  = !dup_next && empty_found_next;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_SCAN: begin
                count_next = count_reg + COUNT_W'(new_val != 8'd0);
                hit_next   = hit_reg | held;
                if (req_reg.nkro) begin
                    if (!first_found_reg && new_val != 8'd0) begin
                        first_found_next = 1'b1;
                        first_next       = 8'({idx_reg, top_bit(new_val)});
                    end
                end else if (idx_reg == '0) begin
                    first_next = new_val;
                end
                if (last) begin
                    state_next = ST_HOLD;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_HOLD: begin
                if (take) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_reg[i] <= '0;
            end
            for (int i = 0; i < BITMAP_BYTES; i++) begin
                bmp_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_SCAN) begin
                if (req_reg.nkro) begin
                    bmp_reg[idx_reg[BMP_IW-1:0]] <= new_val;
                end else begin
                    slot_reg[idx_reg[SLOT_IW-1:0]] <= new_val;
                end
            end
            if (fill_slot) begin
                slot_reg[empty_idx_next] <= req_reg.code;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && state_reg == ST_IDLE) begin
            req_reg <= req;
        end
        idx_reg         <= idx_next;
        dup_reg         <= dup_next;
        empty_found_reg <= empty_found_next;
        empty_idx_reg   <= empty_idx_next;
        count_reg       <= count_next;
        first_reg       <= first_next;
        first_found_reg <= first_found_next;
        hit_reg         <= hit_next;
    end

    assign idle = (state_reg == ST_IDLE);
    assign done = (state_reg == ST_HOLD);

    always_comb begin
        res.query_hit = (req_reg.func == FUNC_QUERY) && hit_reg;
        res.added     = (req_reg.func == FUNC_ADD) && hit_reg;
        res.key_count = count_reg;
        res.first_key = first_reg;
    end

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> state_reg == ST_IDLE)
        else $error("item started while the sequencer was busy");

    a_slot_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HOLD && !req_reg.nkro) |-> count_reg <= COUNT_W'(SLOT_COUNT))
        else $error("slot count exceeds the table size");

    a_prescan_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PRESCAN |-> !req_reg.nkro && req_reg.func == FUNC_ADD)
        else $error("duplicate search entered for an item other than a slot add");

    a_hold_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HOLD && !take) |=> state_reg == ST_HOLD && $stable(count_reg))
        else $error("result lost before it was taken");

endmodule

`default_nettype wire

### rtl/keyboard_report_key_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Ports                        Payload
// s_        in         s_tvalid s_tready s_tdata    func, usage_code
// m_        out        m_tvalid m_tready m_tdata    query_hit, added, key_count, first_key
// cfg_      in         cfg_we cfg_index cfg_wdata   report_protocol, nkro_on
//
// One entry is read, updated and compared per cycle by a single entry unit.
// Slot mode: a transaction scans the SLOT_COUNT slots; an add first prescans them.
// NKRO mode: a transaction scans the BITMAP_BYTES bitmap bytes.
// Reset (aresetn low, synchronous) clears both key stores at once.
// A finished result is held in the output register; the next transaction is
// taken while it waits, and the following result waits until it is taken.

module keyboard_report_key_table
    import kbd_rpt_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [15:0]          s_tdata,   // [1:0] func, [9:2] usage_code, [15:10] zero
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [15:0]               m_tdata,   // [0] query_hit, [1] added,
                                                 // [7:2] key_count, [15:8] first_key
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic                 cfg_wdata
);

    logic        report_protocol_reg;
    logic        nkro_on_reg;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [15:0] m_tdata_reg;

    kr_req_t req;
    kr_res_t res;
    logic    core_idle;
    logic    core_done;
    logic    start;
    logic    take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            report_protocol_reg <= 1'b1;
            nkro_on_reg         <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_REPORT_PROTOCOL: report_protocol_reg <= cfg_wdata;
                CFG_NKRO_ON:         nkro_on_reg         <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_tready = core_idle;
    assign start    = s_tvalid && core_idle;

    always_comb begin
        req.func = s_tdata[FUNC_W-1:0];
        req.code = s_tdata[FUNC_W +: KEY_W];
        req.nkro = report_protocol_reg && nkro_on_reg;
    end

    kbd_rpt_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .req     (req),
        .idle    (core_idle),
        .done    (core_done),
        .take    (take),
        .res     (res)
    );

    // load the output register when it is empty or being drained
    assign take = core_done && (!m_tvalid_reg || m_tready);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (take) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_tdata_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
